>>> hdl/thcu_pkg.sv
// Shared types and constants of the Hybla congestion window engine.
`default_nettype none

package thcu_pkg;

    localparam int PROD_W    = 48;
    localparam int MUL_B_W   = 16;
    localparam int DIV_W     = 48;
    localparam int DIV_CNT_W = 6;

    localparam logic [DIV_CNT_W-1:0] CA_DIV_BITS   = 6'd45;
    localparam logic [DIV_CNT_W-1:0] HALF_DIV_BITS = 6'd31;

    localparam logic [31:0] INIT_WINDOW    = 32'd4380;
    localparam logic [31:0] SSTHRESH_RESET = 32'hFFFF_FFFF;
    localparam logic [15:0] MSS_RESET      = 16'd1460;
    localparam logic [29:0] MAX_WIN_RESET  = 30'd1073725440;
    localparam logic [12:0] CA_GAIN_RESET  = 13'd64;
    localparam logic [11:0] SS_GAIN_RESET  = 12'd127;

    typedef enum logic [2:0] {
        ACT_ACK           = 3'd0,
        ACT_DUPACK        = 3'd1,
        ACT_ECN           = 3'd2,
        ACT_POST_RECOVERY = 3'd3,
        ACT_AFTER_IDLE    = 3'd4
    } thcu_action_t;

    typedef enum logic [2:0] {
        REG_MAX_SEGMENT = 3'd0,
        REG_MAX_WINDOW  = 3'd1,
        REG_RESTART     = 3'd2,
        REG_CA_GAIN     = 3'd3,
        REG_SS_GAIN     = 3'd4
    } thcu_reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CA_MUL1,
        ST_CA_MUL2,
        ST_CA_DIV,
        ST_SS_MUL1,
        ST_SS_MUL2,
        ST_SS_CAP,
        ST_ADD,
        ST_HALF_DIV,
        ST_HALF_MUL,
        ST_DONE
    } thcu_state_t;

    typedef struct packed {
        logic               start;
        logic [PROD_W-1:0]  a;
        logic [MUL_B_W-1:0] b;
    } thcu_mul_req_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [31:0]          divisor;
        logic [DIV_CNT_W-1:0] nbits;
    } thcu_div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } thcu_unit_sts_t;

endpackage

`default_nettype wire

>>> hdl/tcp_hybla_cwnd_update.sv
// Top level: congestion window state, event sequencer and stream ports.
// Post-recovery, after-idle, ignored and unknown events use neither unit; slow start ACKs
// use two 12-bit gain multiplies, the congestion signals a 31-step divide and a 16-bit
// multiply, and a congestion avoidance ACK two 16-bit multiplies and a 45-step divide.
// One event in flight; the next input transfer follows the result load. Reset restores a
// 4380 window, an all-ones threshold, clear flags and the default register values.
`default_nettype none

module tcp_hybla_cwnd_update
    import thcu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [29:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // bytes_acked[19:0], window_limited[20], ack_seq[52:21], send_max_seq[84:53], zero pad
    input  wire logic [87:0] s_tdata,
    // action[2:0]
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // cong_window[31:0], slow_start_threshold[63:32], fast_recovery[64],
    // congestion_recovery[65], zero pad
    output logic [71:0]      m_tdata
);

    thcu_state_t state_reg, state_next;

    logic [15:0] mss_reg;
    logic [29:0] max_win_reg;
    logic        restart_reg;
    logic [12:0] ca_gain_reg;
    logic [11:0] ss_gain_reg;

    logic [31:0] cwnd_reg, cwnd_next;
    logic [31:0] ssth_reg, ssth_next;
    logic        fast_rec_reg, fast_rec_next;
    logic        cong_rec_reg, cong_rec_next;

    logic [2:0]  action_reg;
    logic [19:0] bytes_reg;
    logic        limited_reg;
    logic [31:0] ack_reg;
    logic [31:0] smax_reg;

    logic [PROD_W-1:0] step_reg, step_next;
    logic [31:0]       tmp_reg, tmp_next;
    logic [71:0]       m_tdata_reg, m_tdata_next;
    logic              m_tvalid_reg;
    logic              out_load;

    thcu_mul_req_t     mul_req;
    thcu_unit_sts_t    mul_sts;
    logic [PROD_W-1:0] mul_prod;
    thcu_div_req_t     div_req;
    thcu_unit_sts_t    div_sts;
    logic [DIV_W-1:0]  div_quo;

    logic              win_apply;
    logic [31:0]       win_val;
    logic [31:0]       post_diff;
    logic [31:0]       mss2_w;
    logic [31:0]       mss4_w;
    logic [31:0]       rw_max;
    logic [31:0]       rw_val;
    logic [PROD_W-1:0] cap_sum;
    logic [PROD_W-1:0] add_sum;
    logic [30:0]       segs;
    logic [PROD_W-1:0] bytes_w;
    logic [PROD_W-1:0] tmp_w;

    thcu_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .sts     (mul_sts),
        .product (mul_prod)
    );

    thcu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .sts      (div_sts),
        .quotient (div_quo)
    );

    assign post_diff = ack_reg + ssth_reg - smax_reg;
    assign mss2_w    = {15'd0, mss_reg, 1'b0};
    assign mss4_w    = {14'd0, mss_reg, 2'b0};
    assign rw_max    = (mss2_w > INIT_WINDOW) ? mss2_w : INIT_WINDOW;
    assign rw_val    = restart_reg ? ((mss4_w < rw_max) ? mss4_w : rw_max) : mss2_w;
    assign cap_sum   = step_reg + {16'd0, cwnd_reg};
    assign add_sum   = step_reg + {16'd0, cwnd_reg};
    assign segs      = (div_quo[30:0] < 31'd2) ? 31'd2 : div_quo[30:0];
    assign bytes_w   = {28'd0, bytes_reg};
    assign tmp_w     = {16'd0, tmp_reg};
    assign out_load  = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (action_reg)
                    ACT_ACK:
                    begin
                        if (fast_rec_reg || cong_rec_reg || !limited_reg)
                        begin
                            state_next = ST_DONE;
                        end
                        else if (cwnd_reg > ssth_reg)
                        begin
                            state_next = ST_CA_MUL1;
                        end
                        else
                        begin
                            state_next = ST_SS_MUL1;
                        end
                    end
                    ACT_DUPACK:
                    begin
                        state_next = (fast_rec_reg || (mss_reg == '0)) ? ST_DONE : ST_HALF_DIV;
                    end
                    ACT_ECN:
                    begin
                        state_next = (cong_rec_reg || (mss_reg == '0)) ? ST_DONE : ST_HALF_DIV;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_CA_MUL1:
            begin
                if (mul_sts.done)
                begin
                    state_next = ST_CA_MUL2;
                end
            end
            ST_CA_MUL2:
            begin
                if (mul_sts.done)
                begin
                    state_next = ST_CA_DIV;
                end
            end
            ST_CA_DIV:
            begin
                if (div_sts.done)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_SS_MUL1:
            begin
                if (mul_sts.done)
                begin
                    state_next = ST_SS_MUL2;
                end
            end
            ST_SS_MUL2:
            begin
                if (mul_sts.done)
                begin
                    state_next = ST_SS_CAP;
                end
            end
            ST_SS_CAP:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                state_next = ST_DONE;
            end
            ST_HALF_DIV:
            begin
                if (div_sts.done)
                begin
                    state_next = ST_HALF_MUL;
                end
            end
            ST_HALF_MUL:
            begin
                if (mul_sts.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cwnd_next     = cwnd_reg;
        ssth_next     = ssth_reg;
        fast_rec_next = fast_rec_reg;
        cong_rec_next = cong_rec_reg;
        step_next     = step_reg;
        tmp_next      = tmp_reg;
        m_tdata_next  = m_tdata_reg;
        mul_req       = '0;
        div_req       = '0;
        win_apply     = 1'b0;
        win_val       = '0;
        s_tready      = (state_reg == ST_IDLE);

        case (state_reg)
            ST_EXEC:
            begin
                case (action_reg)
                    ACT_ACK:
                    begin
                        if (!(fast_rec_reg || cong_rec_reg || !limited_reg))
                        begin
                            mul_req.start = 1'b1;
                            if (cwnd_reg > ssth_reg)
                            begin
                                mul_req.a = {35'd0, ca_gain_reg};
                                mul_req.b = mss_reg;
                            end
                            else
                            begin
                                mul_req.a = bytes_w;
                                mul_req.b = {4'd0, ss_gain_reg};
                            end
                        end
                    end
                    ACT_DUPACK, ACT_ECN:
                    begin
                        if ((action_reg == ACT_DUPACK) ? !fast_rec_reg : !cong_rec_reg)
                        begin
                            if (mss_reg == '0)
                            begin
                                win_apply = 1'b1;
                            end
                            else
                            begin
                                div_req.start    = 1'b1;
                                div_req.dividend = {cwnd_reg[31:1], 17'd0};
                                div_req.divisor  = {16'd0, mss_reg};
                                div_req.nbits    = HALF_DIV_BITS;
                            end
                        end
                    end
                    ACT_POST_RECOVERY:
                    begin
                        if (fast_rec_reg)
                        begin
                            if ((post_diff != '0) && !post_diff[31])
                            begin
                                cwnd_next = smax_reg - ack_reg + {16'd0, mss_reg};
                            end
                            else
                            begin
                                cwnd_next = ssth_reg;
                            end
                        end
                        fast_rec_next = 1'b0;
                        cong_rec_next = 1'b0;
                    end
                    ACT_AFTER_IDLE:
                    begin
                        if (cwnd_reg > rw_val)
                        begin
                            cwnd_next = rw_val;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_CA_MUL1:
            begin
                if (mul_sts.done)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = mul_prod;
                    mul_req.b     = mss_reg;
                end
            end
            ST_CA_MUL2:
            begin
                if (mul_sts.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {mul_prod[44:0], 3'd0};
                    div_req.divisor  = cwnd_reg;
                    div_req.nbits    = CA_DIV_BITS;
                end
            end
            ST_CA_DIV:
            begin
                if (div_sts.done)
                begin
                    step_next = (div_quo == '0) ? PROD_W'(1) : div_quo;
                end
            end
            ST_SS_MUL1:
            begin
                if (mul_sts.done)
                begin
                    tmp_next      = mul_prod[31:0];
                    mul_req.start = 1'b1;
                    mul_req.a     = {32'd0, mss_reg};
                    mul_req.b     = {4'd0, ss_gain_reg};
                end
            end
            ST_SS_MUL2:
            begin
                if (mul_sts.done)
                begin
                    step_next = (tmp_w < mul_prod) ? tmp_w : mul_prod;
                end
            end
            ST_SS_CAP:
            begin
                if ((cap_sum > {16'd0, ssth_reg}) && (bytes_w < step_reg))
                begin
                    step_next = bytes_w;
                end
            end
            ST_ADD:
            begin
                if (step_reg != '0)
                begin
                    if (add_sum > {18'd0, max_win_reg})
                    begin
                        cwnd_next = {2'd0, max_win_reg};
                    end
                    else
                    begin
                        cwnd_next = add_sum[31:0];
                    end
                end
            end
            ST_HALF_DIV:
            begin
                if (div_sts.done)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = {17'd0, segs};
                    mul_req.b     = mss_reg;
                end
            end
            ST_HALF_MUL:
            begin
                if (mul_sts.done)
                begin
                    win_apply = 1'b1;
                    win_val   = mul_prod[31:0];
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    m_tdata_next = {6'd0, cong_rec_reg, fast_rec_reg, ssth_reg, cwnd_reg};
                end
            end
            default:
            begin
            end
        endcase

        if (win_apply)
        begin
            if (action_reg == ACT_DUPACK)
            begin
                if (!cong_rec_reg)
                begin
                    ssth_next = win_val;
                end
                fast_rec_next = 1'b1;
                cong_rec_next = 1'b1;
            end
            else
            begin
                ssth_next     = win_val;
                cwnd_next     = win_val;
                cong_rec_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cwnd_reg     <= INIT_WINDOW;
            ssth_reg     <= SSTHRESH_RESET;
            fast_rec_reg <= 1'b0;
            cong_rec_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            mss_reg      <= MSS_RESET;
            max_win_reg  <= MAX_WIN_RESET;
            restart_reg  <= 1'b1;
            ca_gain_reg  <= CA_GAIN_RESET;
            ss_gain_reg  <= SS_GAIN_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            cwnd_reg     <= cwnd_next;
            ssth_reg     <= ssth_next;
            fast_rec_reg <= fast_rec_next;
            cong_rec_reg <= cong_rec_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAX_SEGMENT: mss_reg     <= cfg_data[15:0];
                    REG_MAX_WINDOW:  max_win_reg <= cfg_data;
                    REG_RESTART:     restart_reg <= cfg_data[0];
                    REG_CA_GAIN:     ca_gain_reg <= cfg_data[12:0];
                    REG_SS_GAIN:     ss_gain_reg <= cfg_data[11:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg    <= step_next;
        tmp_reg     <= tmp_next;
        m_tdata_reg <= m_tdata_next;
        if (s_tvalid && s_tready)
        begin
            action_reg  <= s_tuser;
            bytes_reg   <= s_tdata[19:0];
            limited_reg <= s_tdata[20];
            ack_reg     <= s_tdata[52:21];
            smax_reg    <= s_tdata[84:53];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        fast_rec_reg |-> cong_rec_reg)
        else $error("fast recovery set without congestion recovery");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!mul_sts.busy && !div_sts.busy))
        else $error("arithmetic unit busy while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_sts.busy || div_sts.done)
        else $error("divider restarted mid-operation");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_tvalid_reg)
        else $error("result load lost");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |=> $stable(action_reg))
        else $error("event latch changed during processing");

endmodule

`default_nettype wire

>>> hdl/thcu_mul.sv
// Serial-parallel multiplier, one multiplier bit per cycle.
`default_nettype none

module thcu_mul
    import thcu_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire thcu_mul_req_t     req,
    output thcu_unit_sts_t         sts,
    output logic [PROD_W-1:0]      product
);

    logic [PROD_W-1:0]  acc_reg;
    logic [PROD_W-1:0]  a_reg;
    logic [MUL_B_W-1:0] b_reg;
    logic               busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg && (b_reg == '0))
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg <= '0;
            a_reg   <= req.a;
            b_reg   <= req.b;
        end
        else if (busy_reg && (b_reg != '0))
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[PROD_W-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[MUL_B_W-1:1]};
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = busy_reg && (b_reg == '0);
    assign product  = acc_reg;

endmodule

`default_nettype wire

>>> hdl/thcu_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module thcu_div
    import thcu_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire thcu_div_req_t     req,
    output thcu_unit_sts_t         sts,
    output logic [DIV_W-1:0]       quotient
);

    logic [DIV_W-1:0]     dvd_reg;
    logic [31:0]          dsr_reg;
    logic [31:0]          rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic [32:0]          rem_shift;
    logic                 fits;

    assign rem_shift = {rem_reg, dvd_reg[DIV_W-1]};
    assign fits      = rem_shift >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= req.nbits;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            if (fits)
            begin
                rem_reg <= 32'(rem_shift - {1'b0, dsr_reg});
            end
            else
            begin
                rem_reg <= rem_shift[31:0];
            end
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = busy_reg && (cnt_reg == '0);
    assign quotient = quo_reg;

endmodule

`default_nettype wire
